// ----- rtl/mtrc_pkg.sv -----
// Shared types and constants for the motor thermal RC model.
// Holds the configuration bundle, the sequencer micro-op encoding and its schedule.
// No dependencies.
package mtrc_pkg;

    localparam int REG_W      = 24;
    localparam int LIMIT_W    = 48;
    localparam int CFG_DATA_W = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int INPUT_W    = 16;
    localparam int GAIN_SHIFT = 24;
    localparam int FLOW_SHIFT = 16;
    localparam int GEAR_SHIFT = 8;
    localparam int MB_W       = REG_W + 1;

    localparam int TEMP_RESET = 6400;

    localparam int STEP_W     = 4;
    localparam int STEP_COUNT = 16;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEP_COUNT - 1);

    typedef struct packed {
        logic [REG_W-1:0]   ambient_temp;
        logic [REG_W-1:0]   wc_cond;
        logic [REG_W-1:0]   ca_cond;
        logic [REG_W-1:0]   ga_cond;
        logic [REG_W-1:0]   w_gain;
        logic [REG_W-1:0]   c_gain;
        logic [REG_W-1:0]   g_gain;
        logic [LIMIT_W-1:0] limits;
    } cfg_t;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_WC,
        MUL_CA,
        MUL_GA,
        MUL_FS,
        MUL_LO,
        MUL_HI
    } mul_sel_t;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_WC,
        WR_CA,
        WR_GA,
        WR_GH,
        WR_ACCLO,
        WR_ACCHI,
        WR_UPD
    } wr_sel_t;

    typedef enum logic [1:0] {
        NODE_W,
        NODE_C,
        NODE_G
    } node_t;

    typedef struct packed {
        mul_sel_t mul;
        wr_sel_t  wr;
        node_t    node;
    } uop_t;

    typedef struct packed {
        logic capture;
        logic load_out;
        uop_t op;
    } dp_cmd_t;

    localparam uop_t UOP_NOP = '{mul: MUL_NONE, wr: WR_NONE, node: NODE_W};

    // Sequencer schedule: flows first, then gain multiply in two halves per node.
    function automatic uop_t step_uop(input logic [STEP_W-1:0] step);
        uop_t u;
        u = UOP_NOP;
        unique case (step)
            4'd0:    u = '{mul: MUL_WC,   wr: WR_NONE,  node: NODE_W};
            4'd1:    u = '{mul: MUL_CA,   wr: WR_WC,    node: NODE_W};
            4'd2:    u = '{mul: MUL_GA,   wr: WR_CA,    node: NODE_W};
            4'd3:    u = '{mul: MUL_FS,   wr: WR_GA,    node: NODE_W};
            4'd4:    u = '{mul: MUL_LO,   wr: WR_GH,    node: NODE_W};
            4'd5:    u = '{mul: MUL_HI,   wr: WR_ACCLO, node: NODE_W};
            4'd6:    u = '{mul: MUL_NONE, wr: WR_ACCHI, node: NODE_W};
            4'd7:    u = '{mul: MUL_NONE, wr: WR_UPD,   node: NODE_W};
            4'd8:    u = '{mul: MUL_LO,   wr: WR_NONE,  node: NODE_C};
            4'd9:    u = '{mul: MUL_HI,   wr: WR_ACCLO, node: NODE_C};
            4'd10:   u = '{mul: MUL_NONE, wr: WR_ACCHI, node: NODE_C};
            4'd11:   u = '{mul: MUL_NONE, wr: WR_UPD,   node: NODE_C};
            4'd12:   u = '{mul: MUL_LO,   wr: WR_NONE,  node: NODE_G};
            4'd13:   u = '{mul: MUL_HI,   wr: WR_ACCLO, node: NODE_G};
            4'd14:   u = '{mul: MUL_NONE, wr: WR_ACCHI, node: NODE_G};
            4'd15:   u = '{mul: MUL_NONE, wr: WR_UPD,   node: NODE_G};
            default: u = UOP_NOP;
        endcase
        return u;
    endfunction

endpackage

// ----- rtl/mtrc_cfg_regs.sv -----
// Configuration register bank of the motor thermal RC model.
// Decodes the plain write port into the cfg_t bundle; uses mtrc_pkg.
module mtrc_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [mtrc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mtrc_pkg::CFG_DATA_W-1:0]     cfg_data,
    output mtrc_pkg::cfg_t                      cfg
);

    localparam logic [mtrc_pkg::CFG_IDX_W-1:0] REG_AMBIENT = 3'd0;
    localparam logic [mtrc_pkg::CFG_IDX_W-1:0] REG_WC_COND = 3'd1;
    localparam logic [mtrc_pkg::CFG_IDX_W-1:0] REG_CA_COND = 3'd2;
    localparam logic [mtrc_pkg::CFG_IDX_W-1:0] REG_GA_COND = 3'd3;
    localparam logic [mtrc_pkg::CFG_IDX_W-1:0] REG_W_GAIN  = 3'd4;
    localparam logic [mtrc_pkg::CFG_IDX_W-1:0] REG_C_GAIN  = 3'd5;
    localparam logic [mtrc_pkg::CFG_IDX_W-1:0] REG_G_GAIN  = 3'd6;
    localparam logic [mtrc_pkg::CFG_IDX_W-1:0] REG_LIMITS  = 3'd7;

    localparam mtrc_pkg::cfg_t CFG_RESET = '{
        ambient_temp: 24'd6400,
        wc_cond:      24'd65536,
        ca_cond:      24'd65536,
        ga_cond:      24'd65536,
        w_gain:       24'd335,
        c_gain:       24'd335,
        g_gain:       24'd335,
        limits:       48'd386553610395
    };

    mtrc_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_AMBIENT: cfg_reg.ambient_temp <= cfg_data[mtrc_pkg::REG_W-1:0];
                REG_WC_COND: cfg_reg.wc_cond      <= cfg_data[mtrc_pkg::REG_W-1:0];
                REG_CA_COND: cfg_reg.ca_cond      <= cfg_data[mtrc_pkg::REG_W-1:0];
                REG_GA_COND: cfg_reg.ga_cond      <= cfg_data[mtrc_pkg::REG_W-1:0];
                REG_W_GAIN:  cfg_reg.w_gain       <= cfg_data[mtrc_pkg::REG_W-1:0];
                REG_C_GAIN:  cfg_reg.c_gain       <= cfg_data[mtrc_pkg::REG_W-1:0];
                REG_G_GAIN:  cfg_reg.g_gain       <= cfg_data[mtrc_pkg::REG_W-1:0];
                REG_LIMITS:  cfg_reg.limits       <= cfg_data[mtrc_pkg::LIMIT_W-1:0];
                default:     cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/mtrc_ctrl.sv -----
// Sequencer for the motor thermal RC model: input handshake, step counter, output valid.
// Issues dp_cmd_t micro-ops to mtrc_datapath; uses mtrc_pkg.
module mtrc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    output mtrc_pkg::dp_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_RUN    = 3'b010,
        S_FINISH = 3'b100
    } state_t;

    state_t                          state_reg, state_next;
    logic [mtrc_pkg::STEP_W-1:0]     step_reg, step_next;
    logic                            out_valid_reg, out_valid_next;
    logic                            out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd.capture    = 1'b0;
        cmd.load_out   = 1'b0;
        cmd.op         = mtrc_pkg::UOP_NOP;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    step_next   = '0;
                    state_next  = S_RUN;
                end
            end
            S_RUN:
            begin
                cmd.op = mtrc_pkg::step_uop(step_reg);
                if (step_reg == mtrc_pkg::LAST_STEP)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ----- rtl/mtrc_datapath.sv -----
// Datapath of the motor thermal RC model: node temperatures, one shared multiplier,
// flow and accumulator registers, saturation and output register. Uses mtrc_pkg.
module mtrc_datapath #(
    parameter int TEMP_BITS = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mtrc_pkg::dp_cmd_t             cmd,
    input  mtrc_pkg::cfg_t                cfg,
    input  logic [23:0]                   winding_power,
    input  logic signed [15:0]            gear_friction,
    input  logic signed [15:0]            gear_speed,
    input  logic                          force_winding_hot,
    input  logic                          force_case_hot,
    output logic signed [TEMP_BITS-1:0]   winding_temp_out,
    output logic signed [TEMP_BITS-1:0]   case_temp_out,
    output logic signed [TEMP_BITS-1:0]   gear_temp_out,
    output logic                          winding_hot,
    output logic                          case_hot,
    output logic                          gear_hot
);

    localparam int EXT_W   = (TEMP_BITS > mtrc_pkg::REG_W) ? TEMP_BITS : mtrc_pkg::REG_W;
    localparam int DIFF_W  = EXT_W + 1;
    localparam int FLOW_W  = DIFF_W + mtrc_pkg::REG_W - mtrc_pkg::FLOW_SHIFT;
    localparam int NET_W   = FLOW_W + 1;
    localparam int HALF_W  = (NET_W + 1) / 2;
    localparam int MA_W    = (DIFF_W > HALF_W + 1) ? DIFF_W : HALF_W + 1;
    localparam int PRD_W   = MA_W + mtrc_pkg::MB_W;
    localparam int ACC_W   = NET_W + mtrc_pkg::MB_W;
    localparam int DELTA_W = ACC_W - mtrc_pkg::GAIN_SHIFT;
    localparam int SUM_W   = DELTA_W + 1;
    localparam int CMP_W   = EXT_W + 2;

    localparam logic signed [TEMP_BITS-1:0] T_MAX = {1'b0, {(TEMP_BITS-1){1'b1}}};
    localparam logic signed [TEMP_BITS-1:0] T_MIN = {1'b1, {(TEMP_BITS-1){1'b0}}};

    // Captured input item
    logic [23:0]                   power_reg;
    logic signed [15:0]            fric_reg;
    logic signed [15:0]            speed_reg;
    logic                          force_w_reg;
    logic                          force_c_reg;

    // Node state
    logic signed [TEMP_BITS-1:0]   winding_temp_reg;
    logic signed [TEMP_BITS-1:0]   case_temp_reg;
    logic signed [TEMP_BITS-1:0]   gear_temp_reg;

    // Intermediates
    logic signed [PRD_W-1:0]       prod_reg;
    logic signed [FLOW_W-1:0]      wc_reg;
    logic signed [FLOW_W-1:0]      ca_reg;
    logic signed [FLOW_W-1:0]      ga_reg;
    logic signed [FLOW_W-1:0]      gheat_reg;
    logic signed [ACC_W-1:0]       acc_reg;

    // Output register
    logic signed [TEMP_BITS-1:0]   winding_temp_out_reg;
    logic signed [TEMP_BITS-1:0]   case_temp_out_reg;
    logic signed [TEMP_BITS-1:0]   gear_temp_out_reg;
    logic                          winding_hot_reg;
    logic                          case_hot_reg;
    logic                          gear_hot_reg;

    logic signed [DIFF_W-1:0]      ambient_ext;
    logic signed [DIFF_W-1:0]      diff_wc, diff_ca, diff_ga;
    logic signed [NET_W-1:0]       power_ext;
    logic signed [NET_W-1:0]       net_sel;
    logic [mtrc_pkg::REG_W-1:0]    gain_sel;
    logic signed [TEMP_BITS-1:0]   temp_sel;
    logic signed [MA_W-1:0]        mul_a;
    logic signed [mtrc_pkg::MB_W-1:0] mul_b;
    logic signed [PRD_W-1:0]       mul_p;
    logic signed [PRD_W-1:0]       prod_shr;
    logic signed [PRD_W-1:0]       prod_abs;
    logic [PRD_W-1:0]              prod_abs_shr;
    logic signed [FLOW_W-1:0]      flow_val;
    logic signed [FLOW_W-1:0]      gheat_val;
    logic signed [ACC_W-1:0]       acc_hi_term;
    logic signed [ACC_W-1:0]       acc_shr;
    logic signed [DELTA_W-1:0]     delta;
    logic signed [SUM_W-1:0]       sum;
    logic [SUM_W-TEMP_BITS:0]      sum_top;
    logic signed [TEMP_BITS-1:0]   temp_new;
    logic signed [CMP_W-1:0]       lim_w, lim_c, lim_g;

    // Differences for the three conductance paths
    assign ambient_ext = DIFF_W'($signed(cfg.ambient_temp));
    assign diff_wc = DIFF_W'(winding_temp_reg) - DIFF_W'(case_temp_reg);
    assign diff_ca = DIFF_W'(case_temp_reg) - ambient_ext;
    assign diff_ga = DIFF_W'(gear_temp_reg) - ambient_ext;

    assign power_ext = $signed({{(NET_W-24){1'b0}}, power_reg});

    always_comb
    begin
        net_sel  = '0;
        gain_sel = cfg.w_gain;
        temp_sel = winding_temp_reg;
        case (cmd.op.node)
            mtrc_pkg::NODE_W:
            begin
                net_sel  = power_ext - NET_W'(wc_reg);
                gain_sel = cfg.w_gain;
                temp_sel = winding_temp_reg;
            end
            mtrc_pkg::NODE_C:
            begin
                net_sel  = NET_W'(wc_reg) - NET_W'(ca_reg);
                gain_sel = cfg.c_gain;
                temp_sel = case_temp_reg;
            end
            mtrc_pkg::NODE_G:
            begin
                net_sel  = NET_W'(gheat_reg) - NET_W'(ga_reg);
                gain_sel = cfg.g_gain;
                temp_sel = gear_temp_reg;
            end
            default:
            begin
                net_sel  = '0;
                gain_sel = cfg.w_gain;
                temp_sel = winding_temp_reg;
            end
        endcase
    end

    // Shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op.mul)
            mtrc_pkg::MUL_WC:
            begin
                mul_a = MA_W'(diff_wc);
                mul_b = $signed({1'b0, cfg.wc_cond});
            end
            mtrc_pkg::MUL_CA:
            begin
                mul_a = MA_W'(diff_ca);
                mul_b = $signed({1'b0, cfg.ca_cond});
            end
            mtrc_pkg::MUL_GA:
            begin
                mul_a = MA_W'(diff_ga);
                mul_b = $signed({1'b0, cfg.ga_cond});
            end
            mtrc_pkg::MUL_FS:
            begin
                mul_a = MA_W'(fric_reg);
                mul_b = mtrc_pkg::MB_W'(speed_reg);
            end
            mtrc_pkg::MUL_LO:
            begin
                mul_a = $signed({{(MA_W-HALF_W){1'b0}}, net_sel[HALF_W-1:0]});
                mul_b = $signed({1'b0, gain_sel});
            end
            mtrc_pkg::MUL_HI:
            begin
                mul_a = MA_W'($signed(net_sel[NET_W-1:HALF_W]));
                mul_b = $signed({1'b0, gain_sel});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Flow = floor(product / 2^16); gear heat = |friction * speed| / 2^8
    assign prod_shr     = prod_reg >>> mtrc_pkg::FLOW_SHIFT;
    assign flow_val     = prod_shr[FLOW_W-1:0];
    assign prod_abs     = prod_reg[PRD_W-1] ? -prod_reg : prod_reg;
    assign prod_abs_shr = prod_abs >> mtrc_pkg::GEAR_SHIFT;
    assign gheat_val    = $signed(prod_abs_shr[FLOW_W-1:0]);

    // Step change = floor(net * gain / 2^24), then saturate
    assign acc_hi_term = ACC_W'(prod_reg) <<< HALF_W;
    assign acc_shr     = acc_reg >>> mtrc_pkg::GAIN_SHIFT;
    assign delta       = acc_shr[DELTA_W-1:0];
    assign sum         = SUM_W'(temp_sel) + SUM_W'(delta);
    assign sum_top     = sum[SUM_W-1:TEMP_BITS-1];

    always_comb
    begin
        if ((&sum_top) || !(|sum_top))
        begin
            temp_new = sum[TEMP_BITS-1:0];
        end
        else if (sum[SUM_W-1])
        begin
            temp_new = T_MIN;
        end
        else
        begin
            temp_new = T_MAX;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p;
        if (cmd.capture)
        begin
            power_reg   <= winding_power;
            fric_reg    <= gear_friction;
            speed_reg   <= gear_speed;
            force_w_reg <= force_winding_hot;
            force_c_reg <= force_case_hot;
        end
        case (cmd.op.wr)
            mtrc_pkg::WR_WC:    wc_reg    <= flow_val;
            mtrc_pkg::WR_CA:    ca_reg    <= flow_val;
            mtrc_pkg::WR_GA:    ga_reg    <= flow_val;
            mtrc_pkg::WR_GH:    gheat_reg <= gheat_val;
            mtrc_pkg::WR_ACCLO: acc_reg   <= ACC_W'(prod_reg);
            mtrc_pkg::WR_ACCHI: acc_reg   <= acc_reg + acc_hi_term;
            default:            acc_reg   <= acc_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            winding_temp_reg <= TEMP_BITS'(mtrc_pkg::TEMP_RESET);
            case_temp_reg    <= TEMP_BITS'(mtrc_pkg::TEMP_RESET);
            gear_temp_reg    <= TEMP_BITS'(mtrc_pkg::TEMP_RESET);
        end
        else if (cmd.op.wr == mtrc_pkg::WR_UPD)
        begin
            case (cmd.op.node)
                mtrc_pkg::NODE_W: winding_temp_reg <= temp_new;
                mtrc_pkg::NODE_C: case_temp_reg    <= temp_new;
                mtrc_pkg::NODE_G: gear_temp_reg    <= temp_new;
                default:          gear_temp_reg    <= gear_temp_reg;
            endcase
        end
    end

    // Limits in whole degrees, compared as Q.8
    assign lim_w = $signed({{(CMP_W-24){1'b0}}, cfg.limits[15:0], 8'h00});
    assign lim_c = $signed({{(CMP_W-24){1'b0}}, cfg.limits[31:16], 8'h00});
    assign lim_g = $signed({{(CMP_W-24){1'b0}}, cfg.limits[47:32], 8'h00});

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            winding_temp_out_reg <= winding_temp_reg;
            case_temp_out_reg    <= case_temp_reg;
            gear_temp_out_reg    <= gear_temp_reg;
            winding_hot_reg      <= (CMP_W'(winding_temp_reg) > lim_w) || force_w_reg;
            case_hot_reg         <= (CMP_W'(case_temp_reg) > lim_c) || force_c_reg;
            gear_hot_reg         <= (CMP_W'(gear_temp_reg) > lim_g);
        end
    end

    assign winding_temp_out = winding_temp_out_reg;
    assign case_temp_out    = case_temp_out_reg;
    assign gear_temp_out    = gear_temp_out_reg;
    assign winding_hot      = winding_hot_reg;
    assign case_hot         = case_hot_reg;
    assign gear_hot         = gear_hot_reg;

endmodule

// ----- rtl/motor_thermal_rc_model.sv -----
// Motor thermal RC model: winding, case and gearbox temperature nodes, one update per tick.
// Top level; instantiates mtrc_cfg_regs, mtrc_ctrl and mtrc_datapath, uses mtrc_pkg.
// Usage:
//   Input channel (in_valid / in_stall) carries one simulation tick: winding power,
//   gear friction and speed, and the two fault-injection force bits. A transfer
//   happens at a rising edge with in_valid high and in_stall low.
//   Output channel (out_valid / out_stall) returns one result per tick: the three
//   updated temperatures and the three overtemperature flags.
//   Configuration registers are written through cfg_we / cfg_index / cfg_data, one
//   register per cycle, only while no tick is in flight.
// Sequence:
//   after the input transfer the block runs 16 sequencer steps through
//   the single shared multiplier, 25 by 25 bits at the default width (three
//   conductance flows, the friction product, two partial products per node), then
//   loads the output register and raises out_valid. The next tick is taken once
//   the sequencer is back in idle after the load.
// Reset: temperatures return to 25 degC, registers to their defaults, no result held.
// Stall: the result waits in the output register while out_stall is high; the next
//   tick is still taken and computed, then held in the finish step until the
//   output register frees.
module motor_thermal_rc_model #(
    parameter int TEMP_BITS = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // input channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [23:0]                         winding_power,
    input  logic signed [15:0]                  gear_friction,
    input  logic signed [15:0]                  gear_speed,
    input  logic                                force_winding_hot,
    input  logic                                force_case_hot,
    // output channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [TEMP_BITS-1:0]         winding_temp_out,
    output logic signed [TEMP_BITS-1:0]         case_temp_out,
    output logic signed [TEMP_BITS-1:0]         gear_temp_out,
    output logic                                winding_hot,
    output logic                                case_hot,
    output logic                                gear_hot,
    // configuration write port
    input  logic                                cfg_we,
    input  logic [mtrc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mtrc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    mtrc_pkg::cfg_t     cfg;
    mtrc_pkg::dp_cmd_t  cmd;

    // Register bank: plain writes, no read-back
    mtrc_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Sequencer: owns both handshakes and steps the datapath
    mtrc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // Datapath: node state, shared multiplier, output register
    mtrc_datapath #(
        .TEMP_BITS (TEMP_BITS)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .cfg               (cfg),
        .winding_power     (winding_power),
        .gear_friction     (gear_friction),
        .gear_speed        (gear_speed),
        .force_winding_hot (force_winding_hot),
        .force_case_hot    (force_case_hot),
        .winding_temp_out  (winding_temp_out),
        .case_temp_out     (case_temp_out),
        .gear_temp_out     (gear_temp_out),
        .winding_hot       (winding_hot),
        .case_hot          (case_hot),
        .gear_hot          (gear_hot)
    );

endmodule

// ----- rtl/mtrc_checker.sv -----
// Port-level checker for the motor thermal RC model, bound to the top level.
// Sees only top-level ports; uses mtrc_pkg for widths and the step count.
module mtrc_checker #(
    parameter int TEMP_BITS = 24
) (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_stall,
    input logic [23:0]                         winding_power,
    input logic signed [15:0]                  gear_friction,
    input logic signed [15:0]                  gear_speed,
    input logic                                force_winding_hot,
    input logic                                force_case_hot,
    input logic                                out_valid,
    input logic                                out_stall,
    input logic signed [TEMP_BITS-1:0]         winding_temp_out,
    input logic signed [TEMP_BITS-1:0]         case_temp_out,
    input logic signed [TEMP_BITS-1:0]         gear_temp_out,
    input logic                                winding_hot,
    input logic                                case_hot,
    input logic                                gear_hot,
    input logic                                cfg_we,
    input logic [mtrc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input logic [mtrc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic in_xfer;

    assign in_xfer = in_valid && !in_stall;

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("out_valid dropped while stalled");

    // A stalled result keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(winding_temp_out) && $stable(case_temp_out)
            && $stable(gear_temp_out) && $stable(winding_hot) && $stable(case_hot)
            && $stable(gear_hot))
        else $error("result payload changed while stalled");

    // Still busy at the last sequencer step after a transfer
    a_busy_run: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |-> ##(mtrc_pkg::STEP_COUNT) in_stall)
        else $error("input taken again before the update finished");

    // A new result only appears out of a tick that was in work
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result offered without a tick in work");

endmodule

bind motor_thermal_rc_model mtrc_checker #(.TEMP_BITS(TEMP_BITS)) u_mtrc_checker (.*);

// ----- sim/thermal_tb_pkg.sv -----
`timescale 1ns / 1ps
// Types and the temperature tracker for the motor thermal RC model testbench.
// The tracker mirrors the register file and the three node temperatures, and it
// checks returned results in order. Uses mtrc_pkg for the reset temperature.
package thermal_tb_pkg;

    localparam int TEMP_W    = 24;
    localparam int REG_COUNT = 8;
    localparam int FLOW_FRAC = 16;
    localparam int GAIN_FRAC = 24;
    localparam int HEAT_FRAC = 8;

    localparam longint TEMP_MAX = (longint'(1) <<< (TEMP_W - 1)) - 1;
    localparam longint TEMP_MIN = -TEMP_MAX - 1;

    typedef enum logic [2:0] {
        REG_AMBIENT,
        REG_WC_COND,
        REG_CA_COND,
        REG_GA_COND,
        REG_W_GAIN,
        REG_C_GAIN,
        REG_G_GAIN,
        REG_LIMITS
    } reg_index_e;

    typedef struct packed {
        logic [23:0]        winding_power;
        logic signed [15:0] gear_friction;
        logic signed [15:0] gear_speed;
        logic               force_winding_hot;
        logic               force_case_hot;
    } tick_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0] winding_temp_out;
        logic signed [TEMP_W-1:0] case_temp_out;
        logic signed [TEMP_W-1:0] gear_temp_out;
        logic                     winding_hot;
        logic                     case_hot;
        logic                     gear_hot;
    } temp_result_t;

    class thermal_tracker;
        longint       ambient;
        longint       wc_cond;
        longint       ca_cond;
        longint       ga_cond;
        longint       w_gain;
        longint       c_gain;
        longint       g_gain;
        logic [47:0]  limits;
        longint       winding_temp;
        longint       case_temp;
        longint       gear_temp;
        temp_result_t expected_temps[$];
        int           failures;

        function new();
            // register defaults: 25 degC ambient, 1 W/degC, gains of 335 / 2^24
            ambient      = 6400;
            wc_cond      = 65536;
            ca_cond      = 65536;
            ga_cond      = 65536;
            w_gain       = 335;
            c_gain       = 335;
            g_gain       = 335;
            limits       = 48'd386553610395;
            winding_temp = mtrc_pkg::TEMP_RESET;
            case_temp    = mtrc_pkg::TEMP_RESET;
            gear_temp    = mtrc_pkg::TEMP_RESET;
            failures     = 0;
        endfunction

        // Bits above a register's width are dropped.
        function void write_reg(reg_index_e idx, logic [47:0] data);
            case (idx)
                REG_AMBIENT: ambient = longint'($signed(data[23:0]));
                REG_WC_COND: wc_cond = longint'(data[23:0]);
                REG_CA_COND: ca_cond = longint'(data[23:0]);
                REG_GA_COND: ga_cond = longint'(data[23:0]);
                REG_W_GAIN:  w_gain  = longint'(data[23:0]);
                REG_C_GAIN:  c_gain  = longint'(data[23:0]);
                REG_G_GAIN:  g_gain  = longint'(data[23:0]);
                REG_LIMITS:  limits  = data;
                default:     ;
            endcase
        endfunction

        function longint heat_flow(longint diff, longint cond);
            return (diff * cond) >>> FLOW_FRAC;
        endfunction

        function longint temp_change(longint net, longint gain);
            return (net * gain) >>> GAIN_FRAC;
        endfunction

        function longint clamp_temp(longint t);
            if (t > TEMP_MAX)
                return TEMP_MAX;
            if (t < TEMP_MIN)
                return TEMP_MIN;
            return t;
        endfunction

        function logic hotter_than(longint t, logic [15:0] limit_deg);
            return t > longint'(limit_deg) * 256;
        endfunction

        // One tick of the three-node network; both motor nodes use pre-tick values.
        function temp_result_t advance_temps(tick_t t);
            longint       power;
            longint       gear_heat;
            longint       wc;
            longint       ca;
            longint       ga;
            longint       nw;
            longint       nc;
            longint       ng;
            temp_result_t r;
            power = longint'(t.winding_power);
            wc = heat_flow(winding_temp - case_temp, wc_cond);
            ca = heat_flow(case_temp - ambient, ca_cond);
            nw = clamp_temp(winding_temp + temp_change(power - wc, w_gain));
            nc = clamp_temp(case_temp + temp_change(wc - ca, c_gain));
            gear_heat = longint'($signed(t.gear_friction)) * longint'($signed(t.gear_speed));
            if (gear_heat < 0)
                gear_heat = -gear_heat;
            gear_heat = gear_heat >>> HEAT_FRAC;
            ga = heat_flow(gear_temp - ambient, ga_cond);
            ng = clamp_temp(gear_temp + temp_change(gear_heat - ga, g_gain));
            winding_temp = nw;
            case_temp    = nc;
            gear_temp    = ng;
            r.winding_temp_out = nw[TEMP_W-1:0];
            r.case_temp_out    = nc[TEMP_W-1:0];
            r.gear_temp_out    = ng[TEMP_W-1:0];
            r.winding_hot      = hotter_than(nw, limits[15:0]) | t.force_winding_hot;
            r.case_hot         = hotter_than(nc, limits[31:16]) | t.force_case_hot;
            r.gear_hot         = hotter_than(ng, limits[47:32]);
            return r;
        endfunction

        function void note_tick(tick_t t);
            expected_temps.push_back(advance_temps(t));
        endfunction

        function void compare_field(string name, longint want, longint got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
                failures++;
            end
        endfunction

        function void check_result(temp_result_t got);
            temp_result_t want;
            if (expected_temps.size() == 0) begin
                $display("%0t: result with nothing pending, got %p", $time, got);
                failures++;
                return;
            end
            want = expected_temps.pop_front();
            compare_field("winding_temp_out", want.winding_temp_out, got.winding_temp_out);
            compare_field("case_temp_out", want.case_temp_out, got.case_temp_out);
            compare_field("gear_temp_out", want.gear_temp_out, got.gear_temp_out);
            compare_field("winding_hot", want.winding_hot, got.winding_hot);
            compare_field("case_hot", want.case_hot, got.case_hot);
            compare_field("gear_hot", want.gear_hot, got.gear_hot);
        endfunction

        function int outstanding();
            return expected_temps.size();
        endfunction
    endclass

endpackage

// ----- sim/motor_thermal_rc_model_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for motor_thermal_rc_model.
// Depends on mtrc_pkg (RTL) and thermal_tb_pkg (tracker and transfer types).
module motor_thermal_rc_model_tb;

    import thermal_tb_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int PHASE_TICKS  = 106;
    localparam int HOLD_CYCLES  = 240;
    localparam int DRAIN_CYCLES = 40;

    typedef enum int {
        CFG_RANDOM,
        CFG_ZERO,
        CFG_HIGH,
        CFG_LOW
    } cfg_kind_e;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_e;

    // Clock, reset and all block inputs start at known values.
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                             in_valid          = 1'b0;
    logic                             in_stall;
    logic [23:0]                      winding_power     = '0;
    logic signed [15:0]               gear_friction     = '0;
    logic signed [15:0]               gear_speed        = '0;
    logic                             force_winding_hot = 1'b0;
    logic                             force_case_hot    = 1'b0;
    logic                             out_valid;
    logic                             out_stall         = 1'b0;
    logic signed [TEMP_W-1:0]         winding_temp_out;
    logic signed [TEMP_W-1:0]         case_temp_out;
    logic signed [TEMP_W-1:0]         gear_temp_out;
    logic                             winding_hot;
    logic                             case_hot;
    logic                             gear_hot;
    logic                             cfg_we            = 1'b0;
    logic [mtrc_pkg::CFG_IDX_W-1:0]   cfg_index         = '0;
    logic [mtrc_pkg::CFG_DATA_W-1:0]  cfg_data          = '0;

    thermal_tracker tracker;

    int send_gap_pct   = 0;
    int recv_stall_pct = 0;
    bit hold_request   = 1'b0;
    int hold_left      = 0;
    int cycle_count    = 0;

    motor_thermal_rc_model dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .winding_power     (winding_power),
        .gear_friction     (gear_friction),
        .gear_speed        (gear_speed),
        .force_winding_hot (force_winding_hot),
        .force_case_hot    (force_case_hot),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .winding_temp_out  (winding_temp_out),
        .case_temp_out     (case_temp_out),
        .gear_temp_out     (gear_temp_out),
        .winding_hot       (winding_hot),
        .case_hot          (case_hot),
        .gear_hot          (gear_hot),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    always #6 clk = ~clk;

    // Count cycles for the run limit.
    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // Receiver: drive out_stall at the falling edge. A requested hold-off keeps
    // the output stalled for a counted stretch so the block backs up into its input.
    always @(negedge clk)
    begin
        if (hold_request)
        begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // Monitor: check every output transfer at the rising edge.
    always @(posedge clk)
    begin
        temp_result_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.winding_temp_out = winding_temp_out;
            got.case_temp_out    = case_temp_out;
            got.gear_temp_out    = gear_temp_out;
            got.winding_hot      = winding_hot;
            got.case_hot         = case_hot;
            got.gear_hot         = gear_hot;
            tracker.check_result(got);
        end
    end

    // Abort a hung run.
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("%0t: run limit of %0d cycles reached", $time, CYCLE_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    function automatic tick_t tick_of(input logic [23:0] power, input logic [15:0] fric,
                                      input logic [15:0] speed, input logic fw, input logic fc);
        tick_t t;
        t.winding_power     = power;
        t.gear_friction     = fric;
        t.gear_speed        = speed;
        t.force_winding_hot = fw;
        t.force_case_hot    = fc;
        return t;
    endfunction

    // Mostly plausible operating points, alternating heating and cooling
    // stretches so the flags cross their limits; some fully random ticks too.
    function automatic tick_t make_tick(input bit heating);
        tick_t t;
        if ($urandom_range(0, 4) == 0)
        begin
            t.winding_power     = 24'($urandom());
            t.gear_friction     = 16'($urandom());
            t.gear_speed        = 16'($urandom());
            t.force_winding_hot = 1'($urandom());
            t.force_case_hot    = 1'($urandom());
        end
        else
        begin
            t.winding_power = heating ? 24'($urandom_range(0, 1 << 17))
                                      : 24'($urandom_range(0, 1 << 9));
            t.gear_friction = heating ? 16'($urandom_range(0, 3000))
                                      : 16'($urandom_range(0, 300));
            t.gear_speed    = 16'($urandom_range(0, 6000));
            if ($urandom_range(0, 1))
                t.gear_friction = -t.gear_friction;
            if ($urandom_range(0, 1))
                t.gear_speed = -t.gear_speed;
            t.force_winding_hot = ($urandom_range(0, 5) == 0);
            t.force_case_hot    = ($urandom_range(0, 5) == 0);
        end
        return t;
    endfunction

    task automatic set_idling(input idle_mode_e mode);
        case (mode)
            IDLE_NONE:     begin send_gap_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SENDER:   begin send_gap_pct = 55; recv_stall_pct = 0;  end
            IDLE_RECEIVER: begin send_gap_pct = 0;  recv_stall_pct = 55; end
            default:       begin send_gap_pct = 13; recv_stall_pct = 13; end
        endcase
    endtask

    // Offer one tick. Entered and left at a falling edge; valid stays high
    // into the next tick when no idle gap is drawn.
    task automatic send_tick(input tick_t t);
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid          <= 1'b1;
        winding_power     <= t.winding_power;
        gear_friction     <= t.gear_friction;
        gear_speed        <= t.gear_speed;
        force_winding_hot <= t.force_winding_hot;
        force_case_hot    <= t.force_case_hot;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        tracker.note_tick(t);
        @(negedge clk);
    endtask

    // Drop valid and wait until every pending result has come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (tracker.outstanding() != 0)
            @(negedge clk);
    endtask

    // Write all registers for one phase; junk in the upper bits of the
    // 24-bit registers must be ignored by the block.
    task automatic program_regs(input cfg_kind_e kind);
        logic [47:0] vals [REG_COUNT];
        logic [23:0] amb;
        for (int i = 0; i < REG_COUNT; i++)
            vals[i] = 48'({$urandom(), $urandom()});
        case (kind)
            CFG_RANDOM:
            begin
                amb = 24'($urandom_range(0, 60) * 256 + $urandom_range(0, 255));
                if ($urandom_range(0, 3) == 0)
                    amb = -amb;
                vals[REG_AMBIENT][23:0] = amb;
                vals[REG_WC_COND][23:0] = 24'($urandom_range(0, 1 << 18));
                vals[REG_CA_COND][23:0] = 24'($urandom_range(0, 1 << 18));
                vals[REG_GA_COND][23:0] = 24'($urandom_range(0, 1 << 18));
                vals[REG_W_GAIN][23:0]  = 24'($urandom_range(1 << 12, 1 << 20));
                vals[REG_C_GAIN][23:0]  = 24'($urandom_range(1 << 12, 1 << 20));
                vals[REG_G_GAIN][23:0]  = 24'($urandom_range(1 << 12, 1 << 20));
                vals[REG_LIMITS] = {16'($urandom_range(15, 120)),
                                    16'($urandom_range(15, 120)),
                                    16'($urandom_range(15, 120))};
            end
            CFG_ZERO:
            begin
                // open thermal paths, and case and gearbox frozen in place
                vals[REG_WC_COND][23:0] = '0;
                vals[REG_CA_COND][23:0] = '0;
                vals[REG_GA_COND][23:0] = '0;
                vals[REG_W_GAIN][23:0]  = 24'($urandom_range(1 << 12, 1 << 20));
                vals[REG_C_GAIN][23:0]  = '0;
                vals[REG_G_GAIN][23:0]  = '0;
            end
            CFG_HIGH:
            begin
                vals[REG_AMBIENT][23:0] = 24'h7FFFFF;
                for (int i = REG_WC_COND; i <= REG_G_GAIN; i++)
                    vals[i][23:0] = 24'hFFFFFF;
                vals[REG_LIMITS] = 48'hFFFF_FFFF_FFFF;
            end
            default:
            begin
                vals[REG_AMBIENT][23:0] = 24'h800000;
                for (int i = REG_WC_COND; i <= REG_G_GAIN; i++)
                    vals[i][23:0] = 24'hFFFFFF;
                vals[REG_LIMITS] = '0;
            end
        endcase
        for (int i = 0; i < REG_COUNT; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= mtrc_pkg::CFG_IDX_W'(i);
            cfg_data  <= vals[i];
            tracker.write_reg(reg_index_e'(i), vals[i]);
            @(negedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        cfg_kind_e phase_kinds [8];
        phase_kinds = '{CFG_RANDOM, CFG_RANDOM, CFG_ZERO, CFG_RANDOM,
                        CFG_RANDOM, CFG_HIGH, CFG_LOW, CFG_RANDOM};
        tracker = new();

        // Hold reset, release at a falling edge.
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed ticks against the reset register values, no idling:
        // field extremes, both signs of the gear product, forced flags.
        set_idling(IDLE_NONE);
        send_tick(tick_of(24'h000000, 16'h0000, 16'h0000, 1'b0, 1'b0));
        send_tick(tick_of(24'hFFFFFF, 16'h0000, 16'h0000, 1'b0, 1'b0));
        send_tick(tick_of(24'h000000, 16'h8000, 16'h8000, 1'b0, 1'b0));
        send_tick(tick_of(24'h000000, 16'h7FFF, 16'h8000, 1'b0, 1'b0));
        send_tick(tick_of(24'h000000, 16'h8000, 16'h7FFF, 1'b0, 1'b0));
        send_tick(tick_of(24'h000000, 16'h7FFF, 16'h7FFF, 1'b0, 1'b0));
        send_tick(tick_of(24'h000000, 16'h0000, 16'h0000, 1'b1, 1'b0));
        send_tick(tick_of(24'h000000, 16'h0000, 16'h0000, 1'b0, 1'b1));
        send_tick(tick_of(24'h000000, 16'h0000, 16'h0000, 1'b1, 1'b1));
        send_tick(tick_of(24'h000001, 16'hFFFF, 16'h0001, 1'b0, 1'b0));
        send_tick(tick_of(24'h800000, 16'h0100, 16'hFF00, 1'b0, 1'b0));
        send_tick(tick_of(24'h000100, 16'h0000, 16'h7FFF, 1'b0, 1'b0));
        repeat (6)
            send_tick(tick_of(24'hFFFFFF, 16'h8000, 16'h8000, 1'b0, 1'b0));
        send_tick(tick_of(24'h000000, 16'h0000, 16'h0000, 1'b0, 1'b0));
        drain_results();

        // Random phases: new register values each time, rotating idle modes.
        for (int p = 0; p < 8; p++)
        begin
            program_regs(phase_kinds[p]);
            set_idling(idle_mode_e'(p % 4));
            for (int i = 0; i < PHASE_TICKS; i++)
            begin
                // back-pressure burst while the sender keeps offering
                if (p == 4 && i == 30)
                    hold_request = 1'b1;
                send_tick(make_tick(((i / 20) % 2) == 0));
            end
            drain_results();
        end

        // Give the block time to show any stray transfer.
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (tracker.failures == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
